[rtl/core/acr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the random-replacement associative cache
// no dependencies
package acr_pkg;

	localparam int ADDR_W     = 32;
	localparam int DATA_W     = 64;
	localparam int BE_W       = 8;
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 3;
	localparam int LINE_WORDS = 8;
	localparam int WORD_W     = 3;
	localparam int BYTE_OFF   = 3;
	localparam int LINE_SHIFT = BYTE_OFF + WORD_W;
	localparam int TAG_W      = ADDR_W - LINE_SHIFT;
	localparam int LFSR_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int LIU_W      = 5;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ    = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_BUSY    = 3'd2,
		KIND_LINEREQ = 3'd3,
		KIND_WB      = 3'd4
	} kind_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINES_IN_USE = 1'b0,
		CFG_RANDOM_SEED  = 1'b1
	} cfg_reg_e;

	typedef enum logic [1:0] {
		RD_HIT,
		RD_PEND,
		RD_WB
	} rd_src_e;

	typedef enum logic [1:0] {
		OUT_SERVE,
		OUT_BUSY,
		OUT_LINEREQ,
		OUT_WB
	} out_sel_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_BUSY,
		S_MISS,
		S_SERVE,
		S_ALLOC,
		S_DIVI,
		S_DIV,
		S_FIND,
		S_WB_RD,
		S_WB,
		S_FREE,
		S_COPY,
		S_SRV_RD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     latch_req;
		logic     miss_start;
		logic     fill_push;
		logic     clr_pending;
		logic     lfsr_step;
		logic     div_init;
		logic     div_step;
		logic     scan_init;
		logic     scan_step;
		logic     victim_take;
		logic     slot_take;
		logic     k_init;
		logic     k_step;
		logic     mem_rd;
		rd_src_e  rd_src;
		logic     mem_merge;
		logic     copy_wr;
		logic     evict_commit;
		logic     install_commit;
		logic     out_load;
		out_sel_e out_sel;
		logic     out_last;
	} acr_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_e req_cmd;
		logic cmd_valid;
		logic pending;
		logic hit;
		logic fill_last;
		logic need_evict;
		logic div_last;
		logic scan_hit;
		logic scan_free;
		logic k_last;
		logic srv_is_write;
		logic out_free;
	} acr_sts_t;

endpackage

[rtl/core/acr_req_if.sv]
`timescale 1ns / 1ps
// request channel carrying cpu accesses and memory fill words
// depends on acr_pkg
interface acr_req_if import acr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic [BE_W-1:0]   byte_enable;

	modport source (output valid, command, address, write_data, byte_enable, input ready);
	modport sink (input valid, command, address, write_data, byte_enable, output ready);
endinterface

[rtl/core/acr_rsp_if.sv]
`timescale 1ns / 1ps
// result channel carrying responses, line requests and writeback words
// depends on acr_pkg
interface acr_rsp_if import acr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] out_address;
	logic [DATA_W-1:0] out_data;
	logic              was_hit;
	logic              last;

	modport source (output valid, kind, out_address, out_data, was_hit, last, input ready);
	modport sink (input valid, kind, out_address, out_data, was_hit, last, output ready);
endinterface

[rtl/core/acr_cfg_if.sv]
`timescale 1ns / 1ps
// configuration write channel
// depends on acr_pkg
interface acr_cfg_if import acr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/acr_ctrl.sv]
`timescale 1ns / 1ps
// cache controller state machine
// depends on acr_pkg; drives acr_datapath through acr_cmd_t
module acr_ctrl import acr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  acr_sts_t sts,
	output acr_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (!sts.cmd_valid) begin
					state_d = S_IDLE;
				end else if (sts.req_cmd == CMD_FILL) begin
					if (!sts.pending) state_d = S_IDLE;
					else if (sts.fill_last) state_d = S_ALLOC;
					else state_d = S_IDLE;
				end else if (sts.pending) begin
					state_d = S_BUSY;
				end else if (sts.hit) begin
					state_d = S_SERVE;
				end else begin
					state_d = S_MISS;
				end
			end
			S_BUSY, S_MISS, S_SERVE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			S_ALLOC: begin
				state_d = sts.need_evict ? S_DIVI : S_FREE;
			end
			S_DIVI: state_d = S_DIV;
			S_DIV: begin
				if (sts.div_last) state_d = S_FIND;
			end
			S_FIND: begin
				if (sts.scan_hit) state_d = S_WB_RD;
			end
			S_WB_RD: state_d = S_WB;
			S_WB: begin
				if (sts.out_free) state_d = sts.k_last ? S_FREE : S_WB_RD;
			end
			S_FREE: begin
				if (sts.scan_free) state_d = S_COPY;
			end
			S_COPY: begin
				if (sts.k_last) state_d = S_SRV_RD;
			end
			S_SRV_RD: state_d = S_SERVE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.rd_src  = RD_HIT;
		cmd.out_sel = OUT_SERVE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_req = in_valid;
			end
			S_DECODE: begin
				if (sts.cmd_valid && sts.req_cmd == CMD_FILL) begin
					cmd.fill_push = sts.pending;
				end else if (sts.cmd_valid && !sts.pending && sts.hit) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_src = RD_HIT;
				end
			end
			S_BUSY: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = OUT_BUSY;
				cmd.out_last = 1'b1;
			end
			S_MISS: begin
				cmd.out_load   = sts.out_free;
				cmd.out_sel    = OUT_LINEREQ;
				cmd.out_last   = 1'b1;
				cmd.miss_start = sts.out_free;
			end
			S_SERVE: begin
				cmd.out_load  = sts.out_free;
				cmd.out_sel   = OUT_SERVE;
				cmd.out_last  = 1'b1;
				cmd.mem_merge = sts.out_free && sts.srv_is_write;
			end
			S_ALLOC: begin
				cmd.lfsr_step = sts.need_evict;
				cmd.scan_init = !sts.need_evict;
			end
			S_DIVI: cmd.div_init = 1'b1;
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.scan_init = sts.div_last;
			end
			S_FIND: begin
				cmd.victim_take = sts.scan_hit;
				cmd.k_init      = sts.scan_hit;
				cmd.scan_step   = !sts.scan_hit;
			end
			S_WB_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_src = RD_WB;
			end
			S_WB: begin
				cmd.out_load     = sts.out_free;
				cmd.out_sel      = OUT_WB;
				cmd.k_step       = sts.out_free;
				cmd.evict_commit = sts.out_free && sts.k_last;
				cmd.scan_init    = sts.out_free && sts.k_last;
			end
			S_FREE: begin
				cmd.slot_take = sts.scan_free;
				cmd.k_init    = sts.scan_free;
				cmd.scan_step = !sts.scan_free;
			end
			S_COPY: begin
				cmd.copy_wr        = 1'b1;
				cmd.k_step         = 1'b1;
				cmd.install_commit = sts.k_last;
				cmd.clr_pending    = sts.k_last;
			end
			S_SRV_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_src = RD_PEND;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/acr_datapath.sv]
`timescale 1ns / 1ps
// cache datapath: tags, valid bits, line word memory, fill buffer,
// victim selection arithmetic, config registers and result register
// depends on acr_pkg and acr_rsp_if
module acr_datapath import acr_pkg::*; #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CMD_W-1:0]      command,
	input  logic [ADDR_W-1:0]     address,
	input  logic [DATA_W-1:0]     write_data,
	input  logic [BE_W-1:0]       byte_enable,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  acr_cmd_t              cmd,
	output acr_sts_t              sts,
	acr_rsp_if.source             rsp
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int MW    = IW + WORD_W;
	localparam int DEPTH = ENTRIES * LINE_WORDS;
	localparam int CMPW  = (CW > LIU_W) ? CW : LIU_W;
	localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? '1 :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	// request and miss registers
	logic [CMD_W-1:0]  req_cmd_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [DATA_W-1:0] req_data_q;
	logic [BE_W-1:0]   req_be_q;
	logic              pending_q;
	logic              pend_wr_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [DATA_W-1:0] pend_data_q;
	logic [BE_W-1:0]   pend_be_q;
	logic [WORD_W-1:0] fill_cnt_q;
	logic [DATA_W-1:0] fill_buf_q [LINE_WORDS];

	// line state
	logic [TAG_W-1:0]  tags_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]     held_q;
	logic [DATA_W-1:0] words_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [MW-1:0]     maddr_q;
	logic              srv_pend_q;

	// replacement
	logic [LIU_W-1:0]  liu_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] dvd_q;
	logic [CW-1:0]     rem_q;
	logic [3:0]        div_cnt_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     seen_q;
	logic [IW-1:0]     victim_q;
	logic [IW-1:0]     slot_q;
	logic [WORD_W-1:0] k_q;

	// result register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_hit_q;
	logic              out_last_q;

	logic [TAG_W-1:0]  req_tag;
	logic [ENTRIES-1:0] match;
	logic [IW-1:0]     hit_idx;
	logic [CMPW-1:0]   cap;
	logic [CMPW-1:0]   liu_ext;
	logic [CW:0]       div_t;
	logic [MW-1:0]     rd_addr;
	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] srv_data;
	logic [BE_W-1:0]   srv_be;
	logic [ADDR_W-1:0] srv_addr;
	logic              srv_wr;
	logic              out_free;

	assign req_tag = req_addr_q[ADDR_W-1:LINE_SHIFT];

	// tag compare over all lines
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (tags_q[i] == req_tag);
			if (match[i]) hit_idx = hit_idx | IW'(i);
		end
	end

	// effective capacity, clamped to 1..ENTRIES
	always_comb begin
		liu_ext = CMPW'(liu_q);
		if (liu_ext == '0) cap = CMPW'(1);
		else if (liu_ext > CMPW'(ENTRIES)) cap = CMPW'(ENTRIES);
		else cap = liu_ext;
	end

	assign div_t = {rem_q, dvd_q[LFSR_W-1]};

	// serve source: current request on a hit, pending request after a fill
	assign srv_data = srv_pend_q ? pend_data_q : req_data_q;
	assign srv_be   = srv_pend_q ? pend_be_q : req_be_q;
	assign srv_addr = srv_pend_q ? pend_addr_q : req_addr_q;
	assign srv_wr   = srv_pend_q ? pend_wr_q : (req_cmd_q == CMD_WRITE);

	always_comb begin
		for (int b = 0; b < BE_W; b++) mask[8*b +: 8] = {8{srv_be[b]}};
	end

	always_comb begin
		unique case (cmd.rd_src)
			RD_HIT:  rd_addr = {hit_idx, req_addr_q[LINE_SHIFT-1:BYTE_OFF]};
			RD_PEND: rd_addr = {slot_q, pend_addr_q[LINE_SHIFT-1:BYTE_OFF]};
			RD_WB:   rd_addr = {victim_q, k_q};
			default: rd_addr = {victim_q, k_q};
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;

	// status
	always_comb begin
		sts.req_cmd      = cmd_e'(req_cmd_q);
		sts.cmd_valid    = (req_cmd_q == CMD_READ) || (req_cmd_q == CMD_WRITE) ||
		                   (req_cmd_q == CMD_FILL);
		sts.pending      = pending_q;
		sts.hit          = |match;
		sts.fill_last    = fill_cnt_q == WORD_W'(LINE_WORDS - 1);
		sts.need_evict   = CMPW'(held_q) >= cap;
		sts.div_last     = div_cnt_q == 4'd15;
		sts.scan_hit     = valid_q[idx_q] && (seen_q == rem_q);
		sts.scan_free    = !valid_q[idx_q];
		sts.k_last       = k_q == WORD_W'(LINE_WORDS - 1);
		sts.srv_is_write = srv_wr;
		sts.out_free     = out_free;
	end

	// request and miss bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			pend_wr_q   <= 1'b0;
			pend_addr_q <= '0;
			pend_data_q <= '0;
			pend_be_q   <= '0;
			fill_cnt_q  <= '0;
			req_cmd_q   <= '0;
		end else begin
			if (cmd.latch_req) req_cmd_q <= command;
			if (cmd.miss_start) begin
				pending_q   <= 1'b1;
				pend_wr_q   <= req_cmd_q == CMD_WRITE;
				pend_addr_q <= req_addr_q;
				pend_data_q <= req_data_q;
				pend_be_q   <= req_be_q;
				fill_cnt_q  <= '0;
			end
			if (cmd.fill_push) fill_cnt_q <= fill_cnt_q + 1'b1;
			if (cmd.clr_pending) begin
				pending_q  <= 1'b0;
				fill_cnt_q <= '0;
			end
		end
	end

	// request payload and fill buffer
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_addr_q <= address & AMASK;
			req_data_q <= write_data;
			req_be_q   <= byte_enable;
		end
		if (cmd.fill_push) fill_buf_q[fill_cnt_q] <= req_data_q;
	end

	// valid bits and line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			held_q  <= '0;
		end else if (cmd.evict_commit) begin
			valid_q[victim_q] <= 1'b0;
			held_q            <= held_q - 1'b1;
		end else if (cmd.install_commit) begin
			valid_q[slot_q] <= 1'b1;
			held_q          <= held_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.install_commit) tags_q[slot_q] <= pend_addr_q[ADDR_W-1:LINE_SHIFT];
	end

	// line word memory
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q    <= words_q[rd_addr];
			maddr_q    <= rd_addr;
			srv_pend_q <= cmd.rd_src == RD_PEND;
		end
		if (cmd.mem_merge) begin
			words_q[maddr_q] <= (rdata_q & ~mask) | (srv_data & mask);
		end else if (cmd.copy_wr) begin
			words_q[{slot_q, k_q}] <= fill_buf_q[k_q];
		end
	end

	// config registers and lfsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q  <= LIU_W'(16);
			lfsr_q <= LFSR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_LINES_IN_USE: liu_q <= cfg_data[LIU_W-1:0];
				CFG_RANDOM_SEED:  lfsr_q <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
				default: ;
			endcase
		end else if (cmd.lfsr_step) begin
			lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
		end
	end

	// remainder of lfsr by line count, one bit per cycle, then victim scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			idx_q     <= '0;
			seen_q    <= '0;
			victim_q  <= '0;
			slot_q    <= '0;
			k_q       <= '0;
		end else begin
			if (cmd.div_init) begin
				dvd_q     <= lfsr_q;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				dvd_q     <= dvd_q << 1;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_t >= {1'b0, held_q}) rem_q <= CW'(div_t - {1'b0, held_q});
				else rem_q <= div_t[CW-1:0];
			end
			if (cmd.scan_init) begin
				idx_q  <= '0;
				seen_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (valid_q[idx_q]) seen_q <= seen_q + 1'b1;
			end
			if (cmd.victim_take) victim_q <= idx_q;
			if (cmd.slot_take) slot_q <= idx_q;
			if (cmd.k_init) k_q <= '0;
			else if (cmd.k_step) k_q <= k_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_last_q <= cmd.out_last;
			unique case (cmd.out_sel)
				OUT_SERVE: begin
					out_kind_q <= srv_wr ? KIND_ACK : KIND_READ;
					out_addr_q <= {srv_addr[ADDR_W-1:BYTE_OFF], BYTE_OFF'(0)};
					out_data_q <= srv_wr ? '0 : rdata_q;
					out_hit_q  <= !srv_pend_q;
				end
				OUT_BUSY: begin
					out_kind_q <= KIND_BUSY;
					out_addr_q <= {req_addr_q[ADDR_W-1:BYTE_OFF], BYTE_OFF'(0)};
					out_data_q <= '0;
					out_hit_q  <= 1'b0;
				end
				OUT_LINEREQ: begin
					out_kind_q <= KIND_LINEREQ;
					out_addr_q <= {req_tag, LINE_SHIFT'(0)};
					out_data_q <= '0;
					out_hit_q  <= 1'b0;
				end
				OUT_WB: begin
					out_kind_q <= KIND_WB;
					out_addr_q <= {tags_q[victim_q], LINE_SHIFT'(0)};
					out_data_q <= rdata_q;
					out_hit_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.out_address = out_addr_q;
	assign rsp.out_data    = out_data_q;
	assign rsp.was_hit     = out_hit_q;
	assign rsp.last        = out_last_q;

endmodule

[rtl/core/assoc_cache_random_replace_unit.sv]
`timescale 1ns / 1ps
// hit: the request is decoded and its word read, then the result loads once the output
// register is free and the next request is taken after that; busy and line request results
// follow the same path through decode; miss: each fill word is decoded and buffered, and
// the last one starts the lfsr remainder by the line count, the victim scan and the
// victim's writeback when one is needed, then the free line scan, copy and serve
// one item in flight, output stalls hold the controller; reset: all lines invalid,
// no miss pending, lines_in_use 16, lfsr seed 1
module assoc_cache_random_replace_unit import acr_pkg::*; #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	acr_req_if.sink   req,
	acr_rsp_if.source rsp,
	acr_cfg_if.sink   cfg
);

	acr_cmd_t cmd;
	acr_sts_t sts;

	assign cfg.ready = 1'b1;

	// control
	acr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	acr_datapath #(
		.ENTRIES   (ENTRIES),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (req.command),
		.address     (req.address),
		.write_data  (req.write_data),
		.byte_enable (req.byte_enable),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

[tb/sv/assoc_cache_random_replace_unit_tb.sv]
`timescale 1ns / 1ps
// testbench of the random-replacement associative write-back cache
// predicts every response, line request and writeback word; depends on acr_pkg and the
// request, response and config interfaces
module assoc_cache_random_replace_unit_tb;
	import acr_pkg::*;

	localparam int NLINES = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		kind_e             kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              hit;
		logic              last;
	} cache_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	acr_req_if req ();
	acr_rsp_if rsp ();
	acr_cfg_if cfg ();

	assoc_cache_random_replace_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// predicted cache contents
	logic [TAG_W-1:0]  line_tag [NLINES];
	logic              line_vld [NLINES];
	logic [DATA_W-1:0] line_dat [NLINES][LINE_WORDS];
	int                held_lines;
	logic              miss_open;
	logic              miss_is_wr;
	logic [ADDR_W-1:0] miss_addr;
	logic [DATA_W-1:0] miss_data;
	logic [BE_W-1:0]   miss_be;
	logic [DATA_W-1:0] fill_words [LINE_WORDS];
	int                fill_idx;
	logic [LFSR_W-1:0] lfsr;
	logic [LIU_W-1:0]  lines_limit;

	cache_rsp_t expected_q [$];
	int  fail_cnt = 0;
	int  hold_cycles = 0;
	logic long_hold_req = 1'b0;
	int  stall_pct = 20;
	longint cycle_cnt = 0;

	// clock, cycle limit
	initial begin
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void push_rsp(kind_e k, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic h);
		cache_rsp_t r;
		r.kind = k; r.addr = a; r.data = d; r.hit = h; r.last = 1'b0;
		expected_q.push_back(r);
	endfunction

	function automatic logic [DATA_W-1:0] byte_merge(logic [DATA_W-1:0] old,
			logic [DATA_W-1:0] d, logic [BE_W-1:0] be);
		logic [DATA_W-1:0] r;
		r = old;
		for (int b = 0; b < BE_W; b++)
			if (be[b]) r[8*b +: 8] = d[8*b +: 8];
		return r;
	endfunction

	function automatic void access_line(int s, logic wr, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic [BE_W-1:0] be, logic h);
		int w;
		w = a[BYTE_OFF +: WORD_W];
		if (wr) begin
			line_dat[s][w] = byte_merge(line_dat[s][w], d, be);
			push_rsp(KIND_ACK, {a[ADDR_W-1:3], 3'b0}, '0, h);
		end else begin
			push_rsp(KIND_READ, {a[ADDR_W-1:3], 3'b0}, line_dat[s][w], h);
		end
	endfunction

	function automatic void evict_victim();
		int pick, seen, v;
		lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
		if (held_lines == 0) return;
		pick = lfsr % held_lines;
		seen = 0;
		v = -1;
		for (int i = 0; i < NLINES; i++) begin
			if (line_vld[i]) begin
				if (seen == pick && v < 0) v = i;
				seen++;
			end
		end
		if (v < 0) return;
		for (int k = 0; k < LINE_WORDS; k++)
			push_rsp(KIND_WB, {line_tag[v], 6'b0}, line_dat[v][k], 1'b0);
		line_vld[v] = 1'b0;
		held_lines--;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < NLINES; i++)
			if (!line_vld[i]) return i;
		return -1;
	endfunction

	// cache behavior for one accepted request
	function automatic void predict_cache(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic [BE_W-1:0] be);
		int n0, s, lim;
		n0 = expected_q.size();
		if (c == CMD_READ || c == CMD_WRITE) begin
			if (miss_open) begin
				push_rsp(KIND_BUSY, {a[ADDR_W-1:3], 3'b0}, '0, 1'b0);
			end else begin
				s = -1;
				for (int i = 0; i < NLINES; i++)
					if (line_vld[i] && line_tag[i] == a[ADDR_W-1:LINE_SHIFT] && s < 0) s = i;
				if (s >= 0) begin
					access_line(s, c == CMD_WRITE, a, d, be, 1'b1);
				end else begin
					miss_open = 1'b1; miss_is_wr = (c == CMD_WRITE);
					miss_addr = a; miss_data = d; miss_be = be; fill_idx = 0;
					push_rsp(KIND_LINEREQ, {a[ADDR_W-1:LINE_SHIFT], 6'b0}, '0, 1'b0);
				end
			end
		end else if (c == CMD_FILL && miss_open) begin
			fill_words[fill_idx] = d;
			fill_idx++;
			if (fill_idx >= LINE_WORDS) begin
				lim = lines_limit < 1 ? 1 : (lines_limit > NLINES ? NLINES : lines_limit);
				if (held_lines >= lim) evict_victim();
				s = free_slot();
				if (s < 0) begin
					evict_victim();
					s = free_slot();
				end
				if (s >= 0) begin
					line_vld[s] = 1'b1;
					line_tag[s] = miss_addr[ADDR_W-1:LINE_SHIFT];
					for (int k = 0; k < LINE_WORDS; k++) line_dat[s][k] = fill_words[k];
					held_lines++;
					access_line(s, miss_is_wr, miss_addr, miss_data, miss_be, 1'b0);
				end
				miss_open = 1'b0;
				fill_idx = 0;
			end
		end
		if (expected_q.size() > n0) expected_q[$].last = 1'b1;
	endfunction

	// response side: random stalls, long hold-off on request, compare each transfer
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result kind %0d addr %h", $time, rsp.kind,
					rsp.out_address);
				fail_cnt++;
			end else begin
				cache_rsp_t e;
				e = expected_q.pop_front();
				if (rsp.kind !== e.kind || rsp.out_address !== e.addr ||
						rsp.out_data !== e.data || rsp.was_hit !== e.hit ||
						rsp.last !== e.last) begin
					$display("%0t mismatch: expected kind %0d addr %h data %h hit %b last %b",
						$time, e.kind, e.addr, e.data, e.hit, e.last);
					$display("%0t           actual kind %0d addr %h data %h hit %b last %b",
						$time, rsp.kind, rsp.out_address, rsp.out_data, rsp.was_hit,
						rsp.last);
					fail_cnt++;
				end
			end
		end
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_cycles <= 300;
			rsp.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			if ($urandom_range(19) == 0) hold_cycles <= $urandom_range(40, 10);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	task automatic send_item(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d, logic [BE_W-1:0] be);
		int gap;
		gap = ($urandom_range(99) < 70) ? 0 :
			(($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1));
		if (stall_pct == 0) gap = 0;
		repeat (gap) @(posedge clk);
		req.valid <= 1'b1;
		req.command <= c;
		req.address <= a;
		req.write_data <= d;
		req.byte_enable <= be;
		do @(posedge clk); while (!req.ready);
		predict_cache(c, a, d, be);
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_LINES_IN_USE) lines_limit = v[LIU_W-1:0];
		else lfsr = (v == 0) ? 16'd1 : v;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one miss with a full line of fill words
	task automatic miss_and_fill(logic wr, logic [ADDR_W-1:0] a);
		send_item(wr ? CMD_WRITE : CMD_READ, a, rand64(), 8'($urandom_range(255)));
		for (int k = 0; k < LINE_WORDS; k++) begin
			if ($urandom_range(9) == 0)
				send_item($urandom_range(1) ? CMD_READ : CMD_WRITE, $urandom,
					rand64(), 8'($urandom_range(255)));
			send_item(CMD_FILL, $urandom, rand64(), 8'($urandom_range(255)));
		end
	endtask

	task automatic test_directed();
		send_item(CMD_FILL, 32'h0, '1, 8'hFF);              // stray fill
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, '1, 8'hFF);    // unused command
		miss_and_fill(1'b0, 32'hFFFF_FFFF);
		send_item(CMD_READ, 32'hFFFF_FFF8, '0, 8'h00);
		send_item(CMD_WRITE, 32'hFFFF_FFC5, '1, 8'hFF);
		send_item(CMD_WRITE, 32'hFFFF_FFC0, 64'h0, 8'h5A);
		send_item(CMD_READ, 32'hFFFF_FFC0, '0, 8'h0);
		send_item(CMD_WRITE, 32'h0000_0000, 64'hA5A5_5A5A_0F0F_F0F0, 8'h00);
		send_item(CMD_READ, 32'h0000_0040, '0, 8'h0);       // busy
		for (int k = 0; k < LINE_WORDS; k++) send_item(CMD_FILL, '0, rand64(), 8'h0);
		send_item(CMD_READ, 32'h0000_0007, '0, 8'h0);
	endtask

	// mostly hits and misses in a small set of lines with random content
	task automatic test_random(int n);
		logic [ADDR_W-1:0] a;
		int r;
		for (int i = 0; i < n; i++) begin
			a = {26'($urandom_range(23)), 3'($urandom_range(7)), 3'($urandom_range(7))};
			if ($urandom_range(7) == 0) a[ADDR_W-1:12] = 20'($urandom);
			r = $urandom_range(99);
			if (r < 6) send_item(CMD_FILL, $urandom, rand64(), 8'($urandom_range(255)));
			else if (r < 8) send_item(CMD_UNUSED, $urandom, rand64(),
				8'($urandom_range(255)));
			else if (r < 20) miss_and_fill(1'($urandom_range(1)), a);
			else send_item($urandom_range(1) ? CMD_READ : CMD_WRITE, a, rand64(),
				8'($urandom_range(255)));
		end
	endtask

	task automatic test_backpressure();
		long_hold_req = 1'b1;
		for (int i = 0; i < 12; i++) send_item(CMD_READ, 32'h40, '0, 8'h0);
	endtask

	initial begin
		req.valid = 1'b0; req.command = '0; req.address = '0;
		req.write_data = '0; req.byte_enable = '0;
		cfg.valid = 1'b0; cfg.index = CFG_LINES_IN_USE; cfg.data = '0;
		for (int i = 0; i < NLINES; i++) line_vld[i] = 1'b0;
		held_lines = 0; miss_open = 1'b0; fill_idx = 0;
		lfsr = 16'd1; lines_limit = 5'd16;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		write_reg(CFG_LINES_IN_USE, 16'd1);
		write_reg(CFG_RANDOM_SEED, 16'd0);
		test_random(20);
		wait_drained();
		write_reg(CFG_LINES_IN_USE, 16'd4);
		write_reg(CFG_RANDOM_SEED, 16'hFFFF);
		test_random(45);
		wait_drained();
		// lowering the limit below the held lines still evicts one per install
		write_reg(CFG_LINES_IN_USE, 16'd2);
		write_reg(CFG_RANDOM_SEED, 16'h8001);
		test_random(20);
		test_backpressure();
		wait_drained();
		write_reg(CFG_LINES_IN_USE, 16'd0);
		test_random(15);
		wait_drained();
		write_reg(CFG_LINES_IN_USE, 16'd31);
		write_reg(CFG_RANDOM_SEED, 16'($urandom_range(65535, 1)));
		stall_pct = 0;
		test_random(20);
		stall_pct = 20;
		test_random(45);
		wait_drained();

		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
